[design/ipss_pkg.sv]
`timescale 1ns / 1ps

package ipss_pkg;

    // Field widths of the channels and of the register file.
    localparam int STEP_REGS  = 6;
    localparam int STEP_W     = 7;
    localparam int LEVEL_W    = 3;
    localparam int REQ_W      = 11;
    localparam int PERIOD_W   = 16;
    localparam int DELAY_W    = 12;
    localparam int DELAY_MS_W = 22;
    localparam int DIFF_W     = 7;
    localparam int LOW_W      = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [STEP_W-1:0] POWER_MAX = 7'd100;
    localparam int                MS_PER_S  = 1000;

    // x / 20 is taken as (x * RECIP_20) >> RECIP_SHIFT. With x below 2^23
    // the rounding error of the reciprocal never reaches the next integer.
    localparam int                RECIP_SHIFT = 28;
    localparam int                RECIP_W     = 40;
    localparam logic [23:0]       RECIP_20    = 24'd13421773;

    localparam logic [STEP_REGS-1:0][STEP_W-1:0] STEP_RST =
        {7'd100, 7'd100, 7'd80, 7'd60, 7'd40, 7'd20};
    localparam logic [PERIOD_W-1:0]   PERIOD_RST   = 16'd4000;
    localparam logic [DELAY_MS_W-1:0] DELAY_MS_RST = 22'd120000;
    localparam logic [RECIP_W-1:0]    RECIP_RST    =
        RECIP_W'(64'(PERIOD_RST) * 64'(RECIP_20));

    // Item kinds on the input channel.
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_1,
        REG_STEP_2,
        REG_STEP_3,
        REG_STEP_4,
        REG_STEP_5,
        REG_STEP_6,
        REG_SAMPLE_PERIOD,
        REG_RELAY_DELAY
    } t_cfg_reg;

    typedef struct packed {
        logic [STEP_REGS-1:0][STEP_W-1:0] steps;
        logic [PERIOD_W-1:0]              period;
        logic [RECIP_W-1:0]               period_recip;
        logic [DELAY_MS_W-1:0]            delay_ms;
    } t_cfg;

    typedef struct packed {
        logic               apply;
        logic               heating;
        logic               relay;
        logic [LEVEL_W-1:0] level;
        logic [STEP_W-1:0]  power;
        logic [DIFF_W-1:0]  diff;
    } t_apply;

    typedef struct packed {
        logic               command_valid;
        logic [LEVEL_W-1:0] command_level;
        logic               relay_on;
        logic               full_phase;
        logic [STEP_W-1:0]  power_now;
    } t_result;

endpackage

[design/ipss_if.sv]
`timescale 1ns / 1ps

interface ipss_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic                              on_flag;
    logic signed [ipss_pkg::REQ_W-1:0] power_request;

    modport source (output valid, output action, output on_flag, output power_request,
                    input ready);
    modport sink   (input valid, input action, input on_flag, input power_request,
                    output ready);
endinterface

interface ipss_out_if;
    logic                              valid;
    logic                              ready;
    logic                              command_valid;
    logic [ipss_pkg::LEVEL_W-1:0]      command_level;
    logic                              relay_on;
    logic                              full_phase;
    logic [ipss_pkg::STEP_W-1:0]       power_now;

    modport source (output valid, output command_valid, output command_level,
                    output relay_on, output full_phase, output power_now, input ready);
    modport sink   (input valid, input command_valid, input command_level,
                    input relay_on, input full_phase, input power_now, output ready);
endinterface

interface ipss_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ipss_pkg::CFG_IDX_W-1:0]    index;
    logic [ipss_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/induction_power_step_scheduler_top.sv]
`timescale 1ns / 1ps

// Power step scheduler for an induction hob.
// i_in carries two kinds of beat: a request (action high) that stores a
// wanted power, or off when on_flag is low, and a millisecond tick (action
// low). Every tick gives exactly one beat on o_res; a request gives none.
// i_cfg writes the six level thresholds, the sample period and the relay
// off delay; writes are taken at any time but must only be issued while no
// tick is in flight.
// The result of an accepted tick passes through the apply stage register, the
// high-time stage register (where the single period-reciprocal multiplier
// sits) and the output register. The pipeline takes one item every cycle
// while o_res.ready stays high.
// When the receiver stalls, the pipeline goes on accepting until its three
// stage registers are full; i_in.ready then falls and no beat is lost.
// Reset is synchronous and active low: it clears the time base, the power
// and relay state and the window, and returns every configuration register
// to its default value. No clearing pass is needed after reset.
module induction_power_step_scheduler_top #(
    parameter int TIME_BITS  = 32,
    parameter int NUM_LEVELS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipss_in_if.sink       i_in,
    ipss_out_if.source    o_res,
    ipss_cfg_if.sink      i_cfg
);

    ipss_pkg::t_cfg       cfg;
    ipss_pkg::t_apply     apply_info;
    ipss_pkg::t_apply     high_info;
    ipss_pkg::t_result    result;

    logic                 apply_ready;
    logic                 apply_valid;
    logic [TIME_BITS-1:0] apply_time;
    logic                 high_ready;
    logic                 high_valid;
    logic [TIME_BITS-1:0] high_time_stamp;
    logic [TIME_BITS-1:0] high_time;
    logic                 window_ready;
    logic                 out_valid;
    logic                 in_take;
    logic                 cfg_ready;

    assign i_in.ready  = apply_ready;
    assign in_take     = i_in.valid && apply_ready;
    assign i_cfg.ready = cfg_ready;

    ipss_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_wr_ready (cfg_ready),
        .o_cfg      (cfg)
    );

    // Request storage, power application, level search and relay timing.
    ipss_apply #(
        .TIME_BITS  (TIME_BITS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_apply (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_take          (in_take),
        .i_action        (i_in.action),
        .i_on_flag       (i_in.on_flag),
        .i_power_request (i_in.power_request),
        .i_next_ready    (high_ready),
        .o_ready         (apply_ready),
        .o_valid         (apply_valid),
        .o_info          (apply_info),
        .o_time          (apply_time)
    );

    // High time of the window from the distance to the chosen threshold.
    ipss_high #(
        .TIME_BITS (TIME_BITS)
    ) u_high (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (apply_valid),
        .i_info       (apply_info),
        .i_time       (apply_time),
        .i_next_ready (window_ready),
        .o_ready      (high_ready),
        .o_valid      (high_valid),
        .o_info       (high_info),
        .o_time       (high_time_stamp),
        .o_high       (high_time)
    );

    // Window restart, phase choice and the output register.
    ipss_window #(
        .TIME_BITS (TIME_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (high_valid),
        .i_info      (high_info),
        .i_time      (high_time_stamp),
        .i_high      (high_time),
        .i_out_ready (o_res.ready),
        .o_ready     (window_ready),
        .o_valid     (out_valid),
        .o_result    (result)
    );

    assign o_res.valid         = out_valid;
    assign o_res.command_valid = result.command_valid;
    assign o_res.command_level = result.command_level;
    assign o_res.relay_on      = result.relay_on;
    assign o_res.full_phase    = result.full_phase;
    assign o_res.power_now     = result.power_now;

endmodule

[design/ipss_cfg_regs.sv]
`timescale 1ns / 1ps

module ipss_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_valid,
    input  logic [ipss_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [ipss_pkg::CFG_DATA_W-1:0] i_wr_data,
    output logic                            o_wr_ready,
    output ipss_pkg::t_cfg                  o_cfg
);

    ipss_pkg::t_cfg r_cfg;

    assign o_wr_ready = 1'b1;
    assign o_cfg      = r_cfg;

    // The period reciprocal and the delay in milliseconds are worked out as
    // each register is written, so the item path sees them ready-made.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps        <= ipss_pkg::STEP_RST;
            r_cfg.period       <= ipss_pkg::PERIOD_RST;
            r_cfg.period_recip <= ipss_pkg::RECIP_RST;
            r_cfg.delay_ms     <= ipss_pkg::DELAY_MS_RST;
        end else if (i_wr_valid) begin
            case (ipss_pkg::t_cfg_reg'(i_wr_index))
                ipss_pkg::REG_STEP_1: begin
                    r_cfg.steps[0] <= i_wr_data[ipss_pkg::STEP_W-1:0];
                end
                ipss_pkg::REG_STEP_2: begin
                    r_cfg.steps[1] <= i_wr_data[ipss_pkg::STEP_W-1:0];
                end
                ipss_pkg::REG_STEP_3: begin
                    r_cfg.steps[2] <= i_wr_data[ipss_pkg::STEP_W-1:0];
                end
                ipss_pkg::REG_STEP_4: begin
                    r_cfg.steps[3] <= i_wr_data[ipss_pkg::STEP_W-1:0];
                end
                ipss_pkg::REG_STEP_5: begin
                    r_cfg.steps[4] <= i_wr_data[ipss_pkg::STEP_W-1:0];
                end
                ipss_pkg::REG_STEP_6: begin
                    r_cfg.steps[5] <= i_wr_data[ipss_pkg::STEP_W-1:0];
                end
                ipss_pkg::REG_SAMPLE_PERIOD: begin
                    r_cfg.period       <= i_wr_data[ipss_pkg::PERIOD_W-1:0];
                    r_cfg.period_recip <=
                        ipss_pkg::RECIP_W'(i_wr_data[ipss_pkg::PERIOD_W-1:0])
                        * ipss_pkg::RECIP_W'(ipss_pkg::RECIP_20);
                end
                ipss_pkg::REG_RELAY_DELAY: begin
                    r_cfg.delay_ms <=
                        ipss_pkg::DELAY_MS_W'(i_wr_data[ipss_pkg::DELAY_W-1:0])
                        * ipss_pkg::DELAY_MS_W'(ipss_pkg::MS_PER_S);
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

endmodule

[design/ipss_apply.sv]
`timescale 1ns / 1ps

module ipss_apply #(
    parameter int TIME_BITS  = 32,
    parameter int NUM_LEVELS = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ipss_pkg::t_cfg                     i_cfg,
    input  logic                               i_take,
    input  logic                               i_action,
    input  logic                               i_on_flag,
    input  logic signed [ipss_pkg::REQ_W-1:0]  i_power_request,
    input  logic                               i_next_ready,
    output logic                               o_ready,
    output logic                               o_valid,
    output ipss_pkg::t_apply                   o_info,
    output logic [TIME_BITS-1:0]               o_time
);

    localparam int LIMIT = (NUM_LEVELS < ipss_pkg::STEP_REGS) ? NUM_LEVELS
                                                              : ipss_pkg::STEP_REGS;

    logic [TIME_BITS-1:0]                r_time;
    logic signed [ipss_pkg::REQ_W-1:0]   r_pending;
    logic [ipss_pkg::STEP_W-1:0]         r_applied;
    logic [ipss_pkg::LEVEL_W-1:0]        r_level;
    logic [TIME_BITS-1:0]                r_off_time;
    logic                                r_heating;
    logic                                r_relay;
    logic                                r_valid;
    ipss_pkg::t_apply                    r_info;
    logic [TIME_BITS-1:0]                r_out_time;

    logic [TIME_BITS-1:0]                n_time;
    logic signed [ipss_pkg::REQ_W-1:0]   n_pending;
    logic [ipss_pkg::STEP_W-1:0]         n_applied;
    logic [ipss_pkg::LEVEL_W-1:0]        n_level;
    logic [TIME_BITS-1:0]                n_off_time;
    logic                                n_heating;
    logic                                n_relay;

    logic                                need_apply;
    logic [ipss_pkg::STEP_W-1:0]         clamped;
    logic                                found;
    logic [ipss_pkg::LEVEL_W-1:0]        search_level;
    logic [ipss_pkg::DIFF_W-1:0]         search_diff;
    logic [ipss_pkg::DIFF_W-1:0]         n_diff;
    logic [TIME_BITS-1:0]                relay_limit;

    assign o_ready = !r_valid || i_next_ready;
    assign o_valid = r_valid;
    assign o_info  = r_info;
    assign o_time  = r_out_time;

    always_comb begin
        n_time     = r_time + TIME_BITS'(1);
        need_apply = r_pending
                     != {{(ipss_pkg::REQ_W - ipss_pkg::STEP_W){1'b0}}, r_applied};

        if (r_pending[ipss_pkg::REQ_W-1]) begin
            clamped = '0;
        end else if ($unsigned(r_pending) > ipss_pkg::REQ_W'(ipss_pkg::POWER_MAX)) begin
            clamped = ipss_pkg::POWER_MAX;
        end else begin
            clamped = r_pending[ipss_pkg::STEP_W-1:0];
        end

        // First threshold at or above the power; no match keeps the level.
        found        = 1'b0;
        search_level = r_level;
        search_diff  = '0;
        for (int i = 0; i < LIMIT; i++) begin
            if (!found && (clamped <= i_cfg.steps[i])) begin
                found        = 1'b1;
                search_level = ipss_pkg::LEVEL_W'(i + 1);
                search_diff  = i_cfg.steps[i] - clamped;
            end
        end

        n_pending  = r_pending;
        n_applied  = r_applied;
        n_level    = r_level;
        n_off_time = r_off_time;
        n_heating  = r_heating;
        n_diff     = '0;
        if (need_apply) begin
            n_pending = {{(ipss_pkg::REQ_W - ipss_pkg::STEP_W){1'b0}}, clamped};
            n_applied = clamped;
            if (clamped == '0) begin
                n_level    = '0;
                n_off_time = n_time;
                n_heating  = 1'b0;
            end else begin
                n_level    = search_level;
                n_off_time = '0;
                n_heating  = 1'b1;
                n_diff     = search_diff;
            end
        end

        relay_limit = n_off_time + TIME_BITS'(i_cfg.delay_ms);
        if (n_heating) begin
            n_relay = 1'b1;
        end else if (r_relay) begin
            n_relay = !(n_time > relay_limit);
        end else begin
            n_relay = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= '0;
            r_pending  <= '0;
            r_applied  <= '0;
            r_level    <= '0;
            r_off_time <= '0;
            r_heating  <= 1'b0;
            r_relay    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_take) begin
                r_valid <= (i_action == ipss_pkg::ACT_TICK);
            end else if (i_next_ready) begin
                r_valid <= 1'b0;
            end

            if (i_take && (i_action == ipss_pkg::ACT_REQUEST)) begin
                r_pending <= i_on_flag ? i_power_request : '0;
            end else if (i_take) begin
                r_time     <= n_time;
                r_pending  <= n_pending;
                r_applied  <= n_applied;
                r_level    <= n_level;
                r_off_time <= n_off_time;
                r_heating  <= n_heating;
                r_relay    <= n_relay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && (i_action == ipss_pkg::ACT_TICK)) begin
            r_info.apply   <= need_apply;
            r_info.heating <= n_heating;
            r_info.relay   <= n_relay;
            r_info.level   <= n_level;
            r_info.power   <= n_applied;
            r_info.diff    <= n_diff;
            r_out_time     <= n_time;
        end
    end

    ap_heat_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heating |-> r_relay)
        else $error("heating active while the relay is open");

    ap_heat_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heating |-> (r_applied != '0) && (r_applied <= ipss_pkg::POWER_MAX))
        else $error("heating active without a valid applied power");

endmodule

[design/ipss_high.sv]
`timescale 1ns / 1ps

module ipss_high #(
    parameter int TIME_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipss_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    input  ipss_pkg::t_apply       i_info,
    input  logic [TIME_BITS-1:0]   i_time,
    input  logic                   i_next_ready,
    output logic                   o_ready,
    output logic                   o_valid,
    output ipss_pkg::t_apply       o_info,
    output logic [TIME_BITS-1:0]   o_time,
    output logic [TIME_BITS-1:0]   o_high
);

    localparam int PROD_W = ipss_pkg::DIFF_W + ipss_pkg::RECIP_W;
    localparam int WIDE   = (TIME_BITS > ipss_pkg::LOW_W) ? TIME_BITS : ipss_pkg::LOW_W;

    logic                  r_valid;
    ipss_pkg::t_apply      r_info;
    logic [TIME_BITS-1:0]  r_time;
    logic [TIME_BITS-1:0]  r_high;

    logic                  take;
    logic [PROD_W-1:0]     product;
    logic [ipss_pkg::LOW_W-1:0] low_time;
    logic [WIDE-1:0]       high_wide;
    logic [TIME_BITS-1:0]  n_high;

    assign o_ready = !r_valid || i_next_ready;
    assign o_valid = r_valid;
    assign o_info  = r_info;
    assign o_time  = r_time;
    assign o_high  = r_high;
    assign take    = i_valid && o_ready;

    // Low time = period * diff / 20, through the stored period reciprocal.
    always_comb begin
        product   = PROD_W'(i_info.diff) * PROD_W'(i_cfg.period_recip);
        low_time  = product[ipss_pkg::RECIP_SHIFT +: ipss_pkg::LOW_W];
        high_wide = WIDE'(i_cfg.period) - WIDE'(low_time);
        if (i_info.diff != '0) begin
            n_high = high_wide[TIME_BITS-1:0];
        end else begin
            n_high = TIME_BITS'(i_cfg.period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_next_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_info <= i_info;
            r_time <= i_time;
            r_high <= n_high;
        end
    end

endmodule

[design/ipss_window.sv]
`timescale 1ns / 1ps

module ipss_window #(
    parameter int TIME_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ipss_pkg::t_cfg         i_cfg,
    input  logic                   i_valid,
    input  ipss_pkg::t_apply       i_info,
    input  logic [TIME_BITS-1:0]   i_time,
    input  logic [TIME_BITS-1:0]   i_high,
    input  logic                   i_out_ready,
    output logic                   o_ready,
    output logic                   o_valid,
    output ipss_pkg::t_result      o_result
);

    logic                  r_valid;
    logic [TIME_BITS-1:0]  r_window_start;
    logic [TIME_BITS-1:0]  r_high;
    logic                  r_phase;
    ipss_pkg::t_result     r_result;

    logic                  take;
    logic [TIME_BITS-1:0]  n_window_start;
    logic [TIME_BITS-1:0]  n_high;
    logic                  n_phase;
    ipss_pkg::t_result     n_result;
    logic [TIME_BITS-1:0]  window_end;
    logic [TIME_BITS-1:0]  high_end;

    assign o_ready  = !r_valid || i_out_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign take     = i_valid && o_ready;

    always_comb begin
        n_high         = i_info.apply ? i_high : r_high;
        n_window_start = r_window_start;
        n_phase        = r_phase;
        window_end     = r_window_start + TIME_BITS'(i_cfg.period);
        high_end       = '0;

        n_result.command_valid = 1'b0;
        n_result.command_level = '0;

        if (i_info.heating && (i_info.power != '0)) begin
            if (i_time > window_end) begin
                n_window_start = i_time;
            end
            high_end               = n_window_start + n_high;
            n_result.command_valid = 1'b1;
            if (i_time > high_end) begin
                // Low part of the window: one level down, never below zero.
                n_result.command_level = (i_info.level != '0)
                                         ? i_info.level - ipss_pkg::LEVEL_W'(1) : '0;
                n_phase                = 1'b0;
            end else begin
                n_result.command_level = i_info.level;
                n_phase                = 1'b1;
            end
        end else if (i_info.relay) begin
            n_result.command_valid = 1'b1;
        end

        n_result.relay_on   = i_info.relay;
        n_result.full_phase = n_phase;
        n_result.power_now  = i_info.power;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_window_start <= '0;
            r_high         <= '0;
            r_phase        <= 1'b0;
        end else begin
            if (take) begin
                r_valid        <= 1'b1;
                r_window_start <= n_window_start;
                r_high         <= n_high;
                r_phase        <= n_phase;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    ap_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_result.command_valid) |-> (r_result.command_level == '0))
        else $error("command level set without a command");

    ap_cmd_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.command_valid) |-> r_result.relay_on)
        else $error("command sent while the relay is open");

endmodule

[tb/sv/tb_induction_power_step_scheduler_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the induction hob power step scheduler.
// An initial block queues request and tick beats phase by phase and writes the
// registers while the block is idle. A clocked driver feeds the queued beats
// into i_in. A clocked monitor keeps a bit-true software copy of the hob state,
// predicts the result of every accepted tick and compares each result beat
// on o_res with the oldest prediction.
module tb_induction_power_step_scheduler_top;

    localparam int TIME_W        = 32;
    localparam int LEVELS        = 6;
    localparam int SEARCH_LEVELS = (LEVELS < ipss_pkg::STEP_REGS) ? LEVELS
                                                                  : ipss_pkg::STEP_REGS;
    localparam int LOW_DIVISOR   = 20;
    // Three pipeline stages plus margin; also covers requests still in flight.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic                              action;
        logic                              on_flag;
        logic signed [ipss_pkg::REQ_W-1:0] power_request;
    } t_hob_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipss_in_if  in_if ();
    ipss_out_if res_if ();
    ipss_cfg_if cfg_if ();

    induction_power_step_scheduler_top #(
        .TIME_BITS  (TIME_W),
        .NUM_LEVELS (LEVELS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Beats waiting to be driven, and the results predicted but not yet seen.
    t_hob_item          pending_items [$];
    ipss_pkg::t_result  expected_results [$];

    int  send_idle_pct;
    int  stall_pct;
    int  mismatch_count = 0;
    // Set at the rising edge when the beat on i_in was taken.
    logic in_beat_done;

    // Software copy of the register file.
    logic [ipss_pkg::STEP_W-1:0]   cfg_steps [1:ipss_pkg::STEP_REGS];
    logic [ipss_pkg::PERIOD_W-1:0] cfg_period;
    logic [ipss_pkg::DELAY_W-1:0]  cfg_delay_s;

    // Software copy of the hob state.
    logic [TIME_W-1:0]            hob_time;
    logic [TIME_W-1:0]            hob_off_time;
    logic [TIME_W-1:0]            hob_window_start;
    logic [TIME_W-1:0]            hob_high_time;
    int                           hob_pending;
    logic [ipss_pkg::STEP_W-1:0]  hob_power;
    logic [ipss_pkg::LEVEL_W-1:0] hob_level;
    bit                           hob_heating;
    bit                           hob_relay;
    bit                           hob_phase_high;

    always #1 i_clk = ~i_clk;

    // One millisecond tick: advance the clock, apply any changed request,
    // update the relay and work out the command sent this tick.
    function automatic ipss_pkg::t_result hob_tick();
        ipss_pkg::t_result res;
        int                p;
        int                i;
        bit                found;
        longint unsigned   diff;
        longint unsigned   low_ms;
        logic [TIME_W-1:0] relay_limit;

        res = '0;
        hob_time = hob_time + 1'b1;

        // A request only takes effect when it differs from the applied power.
        // A negative request against zero power re-applies zero, which also
        // restarts the relay off delay.
        if (int'(hob_power) != hob_pending) begin
            p = hob_pending;
            if (p > int'(ipss_pkg::POWER_MAX)) begin
                p = int'(ipss_pkg::POWER_MAX);
            end
            if (p < 0) begin
                p = 0;
            end
            hob_pending  = p;
            hob_power    = ipss_pkg::STEP_W'(p);
            hob_off_time = '0;
            hob_heating  = 1'b1;
            diff         = 0;
            if (hob_power == '0) begin
                hob_level    = '0;
                hob_off_time = hob_time;
                hob_heating  = 1'b0;
            end else begin
                // First threshold at or above the power; if none fits the
                // level stays as it was and the whole window is high.
                found = 1'b0;
                for (i = 1; i <= SEARCH_LEVELS; i++) begin
                    if (!found && hob_power <= cfg_steps[i]) begin
                        hob_level = ipss_pkg::LEVEL_W'(i);
                        diff      = cfg_steps[i] - hob_power;
                        found     = 1'b1;
                    end
                end
            end
            // The high time wraps when the low part exceeds the period.
            if (diff != 0) begin
                low_ms        = (64'(cfg_period) * diff) / LOW_DIVISOR;
                hob_high_time = TIME_W'(64'(cfg_period) - low_ms);
            end else begin
                hob_high_time = TIME_W'(cfg_period);
            end
        end

        // Relay switches on at once and off only once the delay has run out.
        if (hob_heating) begin
            hob_relay = 1'b1;
        end else if (hob_relay) begin
            relay_limit = hob_off_time + TIME_W'(64'(cfg_delay_s) * ipss_pkg::MS_PER_S);
            hob_relay   = !(hob_time > relay_limit);
        end

        if (hob_heating && hob_power != '0) begin
            if (hob_time > TIME_W'(hob_window_start + cfg_period)) begin
                hob_window_start = hob_time;
            end
            res.command_valid = 1'b1;
            if (hob_time > TIME_W'(hob_window_start + hob_high_time)) begin
                // Low part of the window: one level down, never below zero.
                res.command_level = (hob_level != '0) ? hob_level - 1'b1 : '0;
                hob_phase_high    = 1'b0;
            end else begin
                res.command_level = hob_level;
                hob_phase_high    = 1'b1;
            end
        end else if (hob_relay) begin
            // Off but the relay still held: a level zero command is sent.
            res.command_valid = 1'b1;
            res.command_level = '0;
        end
        // With no command the full phase flag keeps its last value.
        res.relay_on   = hob_relay;
        res.full_phase = hob_phase_high;
        res.power_now  = hob_power;
        return res;
    endfunction

    task automatic note_mismatch(string what, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Monitor and predictor. Register writes, accepted input beats and result
    // beats are all taken at the rising edge; the prediction for a tick is
    // queued at the edge where the tick is accepted.
    always @(posedge i_clk) begin : track_and_check
        ipss_pkg::t_result want;
        int                k;

        if (!i_rst_n) begin
            in_beat_done <= 1'b0;
            for (k = 1; k <= ipss_pkg::STEP_REGS; k++) begin
                cfg_steps[k] = ipss_pkg::STEP_RST[k-1];
            end
            cfg_period       = ipss_pkg::PERIOD_RST;
            cfg_delay_s      = ipss_pkg::DELAY_W'(ipss_pkg::DELAY_MS_RST / ipss_pkg::MS_PER_S);
            hob_time         = '0;
            hob_off_time     = '0;
            hob_window_start = '0;
            hob_high_time    = '0;
            hob_pending      = 0;
            hob_power        = '0;
            hob_level        = '0;
            hob_heating      = 1'b0;
            hob_relay        = 1'b0;
            hob_phase_high   = 1'b0;
        end else begin
            in_beat_done <= in_if.valid && in_if.ready;

            if (cfg_if.valid && cfg_if.ready) begin
                case (ipss_pkg::t_cfg_reg'(cfg_if.index))
                    ipss_pkg::REG_SAMPLE_PERIOD: begin
                        cfg_period = cfg_if.data[ipss_pkg::PERIOD_W-1:0];
                    end
                    ipss_pkg::REG_RELAY_DELAY: begin
                        cfg_delay_s = cfg_if.data[ipss_pkg::DELAY_W-1:0];
                    end
                    default: begin
                        cfg_steps[int'(cfg_if.index) + 1] =
                            cfg_if.data[ipss_pkg::STEP_W-1:0];
                    end
                endcase
            end

            if (in_if.valid && in_if.ready) begin
                if (in_if.action == ipss_pkg::ACT_TICK) begin
                    expected_results.push_back(hob_tick());
                end else if (!in_if.on_flag) begin
                    hob_pending = 0;
                end else begin
                    hob_pending = int'(in_if.power_request);
                end
            end

            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: result beat arrived with none expected", $time);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.command_valid !== want.command_valid) begin
                        note_mismatch("command_valid", want.command_valid,
                                      res_if.command_valid);
                    end
                    if (res_if.command_level !== want.command_level) begin
                        note_mismatch("command_level", want.command_level,
                                      res_if.command_level);
                    end
                    if (res_if.relay_on !== want.relay_on) begin
                        note_mismatch("relay_on", want.relay_on, res_if.relay_on);
                    end
                    if (res_if.full_phase !== want.full_phase) begin
                        note_mismatch("full_phase", want.full_phase, res_if.full_phase);
                    end
                    if (res_if.power_now !== want.power_now) begin
                        note_mismatch("power_now", want.power_now, res_if.power_now);
                    end
                end
            end
        end
    end

    // Driver. A beat is held until taken; a new one is offered only when the
    // channel is free, so valid gets a single assignment per falling edge.
    // Ready on the result side is redrawn every cycle.
    always @(negedge i_clk) begin : drive_beats
        t_hob_item item_out;

        if (!i_rst_n) begin
            in_if.valid         <= 1'b0;
            in_if.action        <= ipss_pkg::ACT_TICK;
            in_if.on_flag       <= 1'b0;
            in_if.power_request <= '0;
            res_if.ready        <= 1'b0;
        end else begin
            if (!in_if.valid || in_beat_done) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_out = pending_items.pop_front();
                    in_if.valid         <= 1'b1;
                    in_if.action        <= item_out.action;
                    in_if.on_flag       <= item_out.on_flag;
                    in_if.power_request <= item_out.power_request;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_request(bit on, logic signed [ipss_pkg::REQ_W-1:0] power);
        t_hob_item it;

        it.action        = ipss_pkg::ACT_REQUEST;
        it.on_flag       = on;
        it.power_request = power;
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(int count);
        t_hob_item it;

        it.action        = ipss_pkg::ACT_TICK;
        it.on_flag       = 1'($urandom);
        it.power_request = ipss_pkg::REQ_W'($urandom);
        repeat (count) begin
            pending_items.push_back(it);
        end
    endtask

    // Wait until every queued beat is taken and every result has arrived,
    // then let the pipeline empty of trailing requests.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(ipss_pkg::t_cfg_reg sel,
                             logic [ipss_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= sel;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready)) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_all_registers(
        logic [ipss_pkg::CFG_DATA_W-1:0] step_data [ipss_pkg::STEP_REGS],
        logic [ipss_pkg::CFG_DATA_W-1:0] period,
        logic [ipss_pkg::CFG_DATA_W-1:0] delay_s);
        int k;

        for (k = 0; k < ipss_pkg::STEP_REGS; k++) begin
            cfg_write(ipss_pkg::t_cfg_reg'(k), step_data[k]);
        end
        cfg_write(ipss_pkg::REG_SAMPLE_PERIOD, period);
        cfg_write(ipss_pkg::REG_RELAY_DELAY, delay_s);
    endtask

    // Random sessions: mostly a request followed by a run of ticks so that the
    // window and the relay get time to evolve, with off requests, requests at
    // a threshold, out-of-range values and back-to-back requests mixed in.
    task automatic queue_random_session(int n_items);
        int placed;
        int r;
        int n;

        placed = 0;
        while (placed < n_items) begin
            r = $urandom_range(99);
            if (r < 12) begin
                push_request(1'b0, ipss_pkg::REQ_W'($urandom));
            end else if (r < 24) begin
                push_request(1'b1, ipss_pkg::REQ_W'($urandom));
            end else if (r < 34) begin
                push_request(1'b1, '0);
            end else if (r < 50) begin
                push_request(1'b1, ipss_pkg::REQ_W'(
                    cfg_steps[$urandom_range(1, ipss_pkg::STEP_REGS)]));
            end else begin
                push_request(1'b1, ipss_pkg::REQ_W'($urandom_range(1, 100)));
            end
            placed++;
            if ($urandom_range(9) != 0) begin
                n = $urandom_range(1, 14);
                push_ticks(n);
                placed += n;
            end
        end
    endtask

    // Half the items, a full pause of the sender until all results are in,
    // then the other half.
    task automatic run_random_phase(int send_pct, int rx_pct, int n_items);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        queue_random_session(n_items / 2);
        wait_drained();
        queue_random_session(n_items - n_items / 2);
        wait_drained();
    endtask

    initial begin : stimulus
        logic [ipss_pkg::CFG_DATA_W-1:0] step_data [ipss_pkg::STEP_REGS];
        int                              level_pct;
        int                              k;

        i_rst_n       = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        send_idle_pct = 0;
        stall_pct     = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the default registers.
        push_ticks(1);                      // nothing applied: no command
        push_request(1'b1, 11'sd50);        // mid power, partial window
        push_ticks(1);
        push_request(1'b1, 11'sd1023);      // largest request clamps to full power
        push_ticks(1);
        push_request(1'b1, -11'sd1024);     // most negative clamps to zero
        push_ticks(1);                      // relay held on through its delay
        push_request(1'b0, 11'sd77);        // off ignores the value given
        push_ticks(1);
        push_request(1'b1, 11'sd1);         // lowest level with a short high part
        push_ticks(1);
        push_request(1'b1, 11'sd1);         // same request again: nothing reapplied
        push_ticks(1);
        push_request(1'b0, '0);             // back to zero, level zero
        push_ticks(1);
        wait_drained();

        // All thresholds at zero so no step fits: the level stays at zero
        // while heating. Shortest delay lets the relay drop a tick after off.
        for (k = 0; k < ipss_pkg::STEP_REGS; k++) begin
            step_data[k] = '0;
        end
        write_all_registers(step_data, 16'd3, 16'd0);
        push_request(1'b1, 11'sd50);
        push_ticks(5);
        push_request(1'b0, '0);
        push_ticks(2);
        wait_drained();

        // Default thresholds, short window, no relay delay, no idling.
        for (k = 0; k < ipss_pkg::STEP_REGS; k++) begin
            step_data[k] = ipss_pkg::CFG_DATA_W'(ipss_pkg::STEP_RST[k]);
        end
        write_all_registers(step_data, 16'd10, 16'd0);
        run_random_phase(0, 0, 250);

        // Sorted random thresholds, one millisecond window, idling sender.
        level_pct = 0;
        for (k = 0; k < ipss_pkg::STEP_REGS; k++) begin
            level_pct = level_pct + int'($urandom_range(0, 20));
            if (level_pct > 100) begin
                level_pct = 100;
            end
            step_data[k] = ipss_pkg::CFG_DATA_W'(level_pct);
        end
        write_all_registers(step_data, 16'd1, 16'd1);
        run_random_phase(68, 0, 250);

        // Full-width register data so out-of-range thresholds appear, longest
        // window, a long relay delay and a stalling receiver.
        for (k = 0; k < ipss_pkg::STEP_REGS; k++) begin
            step_data[k] = ipss_pkg::CFG_DATA_W'($urandom);
        end
        write_all_registers(step_data, 16'hFFFF, 16'd3600);
        run_random_phase(0, 68, 250);

        // Unsorted random thresholds and a random short window, both sides idle.
        for (k = 0; k < ipss_pkg::STEP_REGS; k++) begin
            step_data[k] = ipss_pkg::CFG_DATA_W'($urandom_range(0, 100));
        end
        write_all_registers(step_data, ipss_pkg::CFG_DATA_W'($urandom_range(2, 40)),
                            16'd0);
        run_random_phase(35, 35, 250);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #400_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
